// File: hdl/vector_speed_magnitude_defines.svh
// assertion macros for the speed magnitude block
`ifndef VECTOR_SPEED_MAGNITUDE_DEFINES_SVH
`define VECTOR_SPEED_MAGNITUDE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define VSM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("vsm implication check failed");

// next-cycle implication, clocked on i_clk, off while in reset
`define VSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("vsm next-cycle check failed");

`endif

// File: hdl/vsm_pkg.sv
package vsm_pkg;

    localparam int          COMP_W         = 32;
    localparam int          SUM_W          = 64;
    localparam int          METRIC_W       = 31;
    localparam int          GAIN_SHIFT     = 6;
    localparam int          TOP_PAIR_SHIFT = 62;
    localparam int          ROOT_STEPS     = 32;
    localparam logic [1:0]  SQ_LAST        = 2'd3;
    localparam logic [METRIC_W-1:0] METRIC_LIMIT = {METRIC_W{1'b1}};

    typedef struct packed {
        logic signed [COMP_W-1:0] x_component;
        logic signed [COMP_W-1:0] y_component;
        logic signed [COMP_W-1:0] z_component;
    } t_item;

    typedef struct packed {
        logic [METRIC_W-1:0] speed_metric;
        logic                saturated;
    } t_result;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       acc_en;
        logic [1:0] sel;
        logic       root_init;
        logic       root_step;
        logic       out_en;
    } t_cmd;

    typedef struct packed {
        logic root_last;
    } t_status;

    function automatic logic [COMP_W-1:0] mag32(input logic [COMP_W-1:0] v);
        return v[COMP_W-1] ? (COMP_W'(0) - v) : v;
    endfunction

endpackage

// File: hdl/vsm_ctrl.sv
module vsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  vsm_pkg::t_status i_status,
    output vsm_pkg::t_cmd   o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_valid;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_cmd     = '0;
        o_cmd.sel = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                // multiply on counts 0..2, add the previous square on counts 1..2
                o_cmd.mul_en = (r_cnt != vsm_pkg::SQ_LAST);
                o_cmd.acc_en = (r_cnt != 2'd0) && (r_cnt != vsm_pkg::SQ_LAST);
                if (r_cnt == vsm_pkg::SQ_LAST) begin
                    o_cmd.root_init = 1'b1;
                    n_state         = ST_ROOT;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.out_en = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= (r_state == ST_DONE);
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

// File: hdl/vsm_dp.sv
module vsm_dp #(
    parameter int FRACTION_BITS = 12
) (
    input  logic             i_clk,
    input  vsm_pkg::t_cmd    i_cmd,
    input  vsm_pkg::t_item   i_item,
    output vsm_pkg::t_status o_status,
    output vsm_pkg::t_result o_result
);

    logic [vsm_pkg::COMP_W-1:0] r_mag [3];
    logic [vsm_pkg::COMP_W-1:0] w_mag;
    logic [vsm_pkg::SUM_W-1:0]  w_prod, r_prod, r_sum, w_total, w_trial;
    logic [vsm_pkg::SUM_W-1:0]  r_rad, r_root, r_pair;
    vsm_pkg::t_result           r_result, w_result;

    always_comb begin
        case (i_cmd.sel)
            2'd0:    w_mag = r_mag[0];
            2'd1:    w_mag = r_mag[1];
            2'd2:    w_mag = r_mag[2];
            default: w_mag = '0;
        endcase
    end

    assign w_prod  = vsm_pkg::SUM_W'(w_mag) * vsm_pkg::SUM_W'(w_mag);
    assign w_total = r_sum + r_prod;
    assign w_trial = r_root + r_pair;

    // root below 2^25 fits after the gain shift
    always_comb begin
        w_result.saturated    = |r_root[vsm_pkg::COMP_W-1:vsm_pkg::METRIC_W-vsm_pkg::GAIN_SHIFT];
        w_result.speed_metric = w_result.saturated ? vsm_pkg::METRIC_LIMIT :
            {r_root[vsm_pkg::METRIC_W-vsm_pkg::GAIN_SHIFT-1:0],
             {vsm_pkg::GAIN_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag[0] <= vsm_pkg::mag32(i_item.x_component);
            r_mag[1] <= vsm_pkg::mag32(i_item.y_component);
            r_mag[2] <= vsm_pkg::mag32(i_item.z_component);
            r_sum    <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_en) begin
            r_sum <= w_total;
        end
        if (i_cmd.root_init) begin
            r_rad  <= w_total >> FRACTION_BITS;
            r_root <= '0;
            r_pair <= vsm_pkg::SUM_W'(1) << vsm_pkg::TOP_PAIR_SHIFT;
        end
        if (i_cmd.root_step) begin
            if (r_rad >= w_trial) begin
                r_rad  <= r_rad - w_trial;
                r_root <= (r_root >> 1) + r_pair;
            end else begin
                r_root <= r_root >> 1;
            end
            r_pair <= r_pair >> 2;
        end
        if (i_cmd.out_en) begin
            r_result <= w_result;
        end
    end

    assign o_status.root_last = r_pair[0];
    assign o_result           = r_result;

endmodule

// File: hdl/vector_speed_magnitude.sv
// each item runs the load, three shared-multiplier squares, a root load, the 32-step
// bit-pair square root and an output state; the result strobe is registered from the
// output state, and a new item is taken only after the last one finishes (busy)
// reset: synchronous active-low i_rst_n returns the controller to idle, no result pending
// the receiver cannot stall: o_valid is a one-cycle strobe, busy only gates new starts
module vector_speed_magnitude #(
    parameter int FRACTION_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  vsm_pkg::t_item   i_item,
    output logic             o_valid,
    output vsm_pkg::t_result o_result
);

    // command and status between the sequencer and the datapath
    vsm_pkg::t_cmd    w_cmd;
    vsm_pkg::t_status w_status;

    // sequencer: idle, three squares (two accumulated, the last added at the root load), 32 root steps, output
    vsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // datapath: magnitudes, shared 32x32 squarer, 64-bit sum, bit-pair root,
    // gain shift by 6 (times 64) with saturation into the result register
    vsm_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_status (w_status),
        .o_result (o_result)
    );

endmodule

// File: hdl/vsm_checker.sv
`include "vector_speed_magnitude_defines.svh"

module vsm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input vsm_pkg::t_result o_result
);

    // start transfer to result strobe
    `VSM_ASSERT_IMP(a_latency, start && !busy, ##38 o_valid)
    // a transfer always makes the block busy
    `VSM_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    // the strobe comes with the block free again
    `VSM_ASSERT_IMP(a_valid_not_busy, o_valid, !busy)
    // checks that a clamped metric is the limit; an unclamped metric is a multiple of 64
    `VSM_ASSERT_IMP(a_sat_value, o_valid && o_result.saturated,
        o_result.speed_metric == vsm_pkg::METRIC_LIMIT)

endmodule

bind vector_speed_magnitude vsm_checker u_vsm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
